// ===== hdl/itdrc_pkg.sv =====
// Shared types, constants and the ones-complement adder for the IPv4/TCP rewrite block.
`default_nettype none

package itdrc_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_FRAME_DEF   = 2048;
  localparam int LINK_HEADER_DEF = 14;

  // Result queue sizing.
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // Width of the packet length carried to the checksum finish stage.
  localparam int LEN_W = 16;

  // Result word kinds.
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_PATCH = 1'b1;

  // IP and TCP header offsets and limits.
  localparam int IP_CSUM_HI     = 10;
  localparam int IP_CSUM_LO     = 11;
  localparam int IP_SRC_FIRST   = 12;
  localparam int IP_SRC_END     = 16;
  localparam int IP_DST_FIRST   = 16;
  localparam int IP_DST_LAST    = 19;
  localparam int MIN_IP_HEADER  = 20;
  localparam int TCP_MIN_HEADER = 20;
  localparam int TCP_CHECK_POS  = 16;
  localparam logic [15:0] PROTO_TCP = 16'd6;

  // Everything the finish stage needs to build a patch word.
  typedef struct packed {
    logic [15:0]      header_sum;
    logic [15:0]      segment_sum;
    logic [7:0]       pending_high_byte;
    logic [31:0]      source_address;
    logic [31:0]      target_address;
    logic [5:0]       header_length;
    logic [LEN_W-1:0] ip_len;
  } frame_sum_t;

  // One word leaving the parse stage: a packet byte or a frame summary.
  typedef struct packed {
    logic       patch;
    logic [7:0] data;
    frame_sum_t sum;
  } parse_item_t;

  // One result word as seen on the output channel.
  typedef struct packed {
    logic        kind;
    logic [7:0]  out_byte;
    logic        out_last;
    logic [15:0] ip_checksum;
    logic [15:0] tcp_checksum;
    logic [6:0]  tcp_check_offset;
    logic        malformed;
  } result_t;

  // Ones-complement add with end-around carry. Both operands stay within 16 bits.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = {1'b0, s[15:0]} + {16'd0, s[16]};
    return f[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/itdrc_parse.sv =====
// Parse stage: strips the link header, rewrites bytes and keeps the running sums.
`default_nettype none

module itdrc_parse #(
  parameter int MAX_FRAME         = itdrc_pkg::MAX_FRAME_DEF,
  parameter int LINK_HEADER_BYTES = itdrc_pkg::LINK_HEADER_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   accept,
  input  wire logic [7:0]             frame_byte,
  input  wire logic                   frame_last,
  input  wire logic [31:0]            target_address,
  output logic                        item_valid,
  output itdrc_pkg::parse_item_t      item,
  output logic                        patch_pending
);

  localparam int POS_W = $clog2(MAX_FRAME + 1);
  localparam logic [POS_W-1:0] LINK_POS = POS_W'(LINK_HEADER_BYTES);
  localparam logic [POS_W-1:0] MAX_POS  = POS_W'(MAX_FRAME);

  // Per-frame state.
  logic [POS_W-1:0] byte_position;
  logic [5:0]       header_length;
  logic [31:0]      source_address;
  logic [15:0]      header_sum;
  logic [15:0]      segment_sum;
  logic [7:0]       pending_high_byte;

  // Summary held for the patch word that follows the last data byte.
  itdrc_pkg::frame_sum_t held_sum;

  // Next-state and datapath signals.
  logic                  in_range;
  logic                  echo;
  logic [POS_W-1:0]      p;
  logic [POS_W-1:0]      byte_position_next;
  logic [5:0]            header_length_next;
  logic [31:0]           source_address_next;
  logic [15:0]           header_sum_next;
  logic [15:0]           segment_sum_next;
  logic [7:0]            pending_high_byte_next;
  logic [7:0]            out_b;
  logic [POS_W-1:0]      tcp_at;
  logic [15:0]           word;
  logic [POS_W-1:0]      ip_len;
  itdrc_pkg::frame_sum_t sum_now;

  // Byte rewrite and running sums for the byte at the input.
  always_comb begin
    in_range           = byte_position < MAX_POS;
    echo               = in_range && (byte_position >= LINK_POS);
    p                  = byte_position - LINK_POS;
    byte_position_next = in_range ? byte_position + POS_W'(1) : byte_position;

    // The header length comes from the low nibble of the first IP byte.
    header_length_next = header_length;
    if (echo && p == '0) begin
      header_length_next = {frame_byte[3:0], 2'b00};
    end

    // The source address shifts in over its four bytes.
    source_address_next = source_address;
    if (echo && p >= POS_W'(itdrc_pkg::IP_SRC_FIRST) && p < POS_W'(itdrc_pkg::IP_SRC_END)) begin
      source_address_next = {source_address[23:0], frame_byte};
    end

    // Zero the IP checksum, replace the destination, zero the TCP checksum.
    out_b = frame_byte;
    if (p == POS_W'(itdrc_pkg::IP_CSUM_HI) || p == POS_W'(itdrc_pkg::IP_CSUM_LO)) begin
      out_b = 8'h00;
    end
    if (p >= POS_W'(itdrc_pkg::IP_DST_FIRST) && p <= POS_W'(itdrc_pkg::IP_DST_LAST)) begin
      case (p[1:0])
        2'd0:    out_b = target_address[31:24];
        2'd1:    out_b = target_address[23:16];
        2'd2:    out_b = target_address[15:8];
        default: out_b = target_address[7:0];
      endcase
    end
    tcp_at = POS_W'(header_length_next) + POS_W'(itdrc_pkg::TCP_CHECK_POS);
    if (header_length_next >= 6'(itdrc_pkg::MIN_IP_HEADER) &&
        (p == tcp_at || p == tcp_at + POS_W'(1))) begin
      out_b = 8'h00;
    end

    // Even offsets hold the high byte; odd offsets complete a word for one sum.
    word                   = {pending_high_byte, out_b};
    header_sum_next        = header_sum;
    segment_sum_next       = segment_sum;
    pending_high_byte_next = pending_high_byte;
    if (echo) begin
      if (!p[0]) begin
        pending_high_byte_next = out_b;
      end else if (p < POS_W'(header_length_next)) begin
        header_sum_next = itdrc_pkg::oc_add(header_sum, word);
      end else begin
        segment_sum_next = itdrc_pkg::oc_add(segment_sum, word);
      end
    end

    // IP length after this byte, for the frame summary.
    ip_len = (byte_position_next > LINK_POS) ? byte_position_next - LINK_POS : '0;

    sum_now.header_sum        = header_sum_next;
    sum_now.segment_sum       = segment_sum_next;
    sum_now.pending_high_byte = pending_high_byte_next;
    sum_now.source_address    = source_address_next;
    sum_now.target_address    = target_address;
    sum_now.header_length     = header_length_next;
    sum_now.ip_len            = itdrc_pkg::LEN_W'(ip_len);
  end

  // Frame state and stage valid. The state clears after the last byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      header_length     <= '0;
      source_address    <= '0;
      header_sum        <= '0;
      segment_sum       <= '0;
      pending_high_byte <= '0;
      item_valid        <= 1'b0;
      patch_pending     <= 1'b0;
    end else if (patch_pending) begin
      item_valid    <= 1'b1;
      patch_pending <= 1'b0;
    end else if (accept) begin
      item_valid    <= echo || frame_last;
      patch_pending <= echo && frame_last;
      if (frame_last) begin
        byte_position     <= '0;
        header_length     <= '0;
        source_address    <= '0;
        header_sum        <= '0;
        segment_sum       <= '0;
        pending_high_byte <= '0;
      end else begin
        byte_position     <= byte_position_next;
        header_length     <= header_length_next;
        source_address    <= source_address_next;
        header_sum        <= header_sum_next;
        segment_sum       <= segment_sum_next;
        pending_high_byte <= pending_high_byte_next;
      end
    end else begin
      item_valid <= 1'b0;
    end
  end

  // Stage payload. A last byte with no data goes straight out as a summary.
  always_ff @(posedge clk) begin
    if (patch_pending) begin
      item.patch <= 1'b1;
      item.sum   <= held_sum;
    end else if (accept) begin
      item.patch <= !echo;
      item.data  <= out_b;
      item.sum   <= sum_now;
      held_sum   <= sum_now;
    end
  end

  // No word is taken while the held summary is being issued.
  assert property (@(posedge clk) disable iff (rst) patch_pending |-> !accept)
    else $error("word accepted while a patch summary was pending");

  // A pending summary is issued in the very next cycle.
  assert property (@(posedge clk) disable iff (rst)
    patch_pending |=> (item_valid && item.patch && !patch_pending))
    else $error("pending patch summary was not issued");

  // The frame position never runs past the frame limit.
  assert property (@(posedge clk) disable iff (rst) byte_position <= MAX_POS)
    else $error("byte position beyond frame limit");

endmodule

`default_nettype wire

// ===== hdl/itdrc_finish.sv =====
// Finish stage: passes data bytes and turns a frame summary into the checksum patch word.
`default_nettype none

module itdrc_finish (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   item_valid,
  input  wire itdrc_pkg::parse_item_t item,
  output logic                        res_valid,
  output itdrc_pkg::result_t          res
);

  logic [15:0]        seg_len;
  logic               bad;
  logic [15:0]        pad;
  logic [18:0]        total;
  logic [16:0]        fold1;
  logic [16:0]        fold2;
  itdrc_pkg::result_t res_next;

  // Pseudo header plus segment sum, then two folds back to 16 bits.
  always_comb begin
    seg_len = item.sum.ip_len - 16'(item.sum.header_length);
    bad     = (item.sum.header_length < 6'(itdrc_pkg::MIN_IP_HEADER)) ||
              (item.sum.ip_len < 16'(item.sum.header_length) +
                                 16'(itdrc_pkg::TCP_MIN_HEADER));
    // An odd trailing byte is summed as the high byte of a padded word.
    pad     = item.sum.ip_len[0] ? {item.sum.pending_high_byte, 8'h00} : 16'h0000;
    total   = 19'(item.sum.segment_sum) + 19'(pad) +
              19'(item.sum.source_address[31:16]) + 19'(item.sum.source_address[15:0]) +
              19'(item.sum.target_address[31:16]) + 19'(item.sum.target_address[15:0]) +
              19'(itdrc_pkg::PROTO_TCP) + 19'(seg_len);
    fold1   = 17'(total[15:0]) + 17'(total[18:16]);
    fold2   = 17'(fold1[15:0]) + 17'(fold1[16]);

    res_next = '0;
    if (!item.patch) begin
      res_next.kind     = itdrc_pkg::KIND_DATA;
      res_next.out_byte = item.data;
    end else begin
      res_next.kind     = itdrc_pkg::KIND_PATCH;
      res_next.out_last = 1'b1;
      if (bad) begin
        res_next.malformed = 1'b1;
      end else begin
        res_next.ip_checksum      = ~item.sum.header_sum;
        res_next.tcp_checksum     = ~fold2[15:0];
        res_next.tcp_check_offset = 7'(item.sum.header_length) +
                                    7'(itdrc_pkg::TCP_CHECK_POS);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

`default_nettype wire

// ===== hdl/itdrc_out_fifo.sv =====
// Result queue between the pipeline and the output channel.
`default_nettype none

module itdrc_out_fifo (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  input  wire itdrc_pkg::result_t             push_data,
  input  wire logic                           pop,
  output itdrc_pkg::result_t                  head,
  output logic                                not_empty,
  output logic [itdrc_pkg::OUT_CNT_W-1:0]     count
);

  localparam int PTR_W = itdrc_pkg::OUT_PTR_W;
  localparam int CNT_W = itdrc_pkg::OUT_CNT_W;

  itdrc_pkg::result_t entries [itdrc_pkg::OUT_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign head      = entries[rd_ptr];
  assign not_empty = count != '0;

  // Upstream credit keeps a word from ever landing in a full queue.
  assert property (@(posedge clk) disable iff (rst)
    push |-> (count < CNT_W'(itdrc_pkg::OUT_DEPTH)))
    else $error("result queue overflow");

endmodule

`default_nettype wire

// ===== hdl/ipv4_tcp_dest_rewrite_checksum_top.sv =====
// Top level of the IPv4/TCP destination rewrite and checksum block.
//
// Takes an Ethernet frame one byte per word, drops the link header and sends
// the IP packet on as data words (kind 0) with the destination address replaced
// by target_address and both checksum fields zeroed. After the last frame byte a
// patch word (kind 1, out_last set) carries the IP header checksum, the TCP
// checksum over the segment and pseudo header, and the offset of the TCP
// checksum field, or flags the frame as malformed. While the output is ready,
// one byte is taken every clock cycle; the only pause follows a last byte that
// is also echoed, while the parse stage issues the patch word. A word reaches
// the output through the parse register, the finish register and an eight-entry
// result queue; the patch word after an echoed last byte is issued from the
// summary held in the parse stage. Input is taken only while that queue has
// room for every word in flight plus the two words a last byte can produce, so
// output back-pressure stalls the input.
`default_nettype none

module ipv4_tcp_dest_rewrite_checksum_top #(
  parameter int MAX_FRAME         = itdrc_pkg::MAX_FRAME_DEF,
  parameter int LINK_HEADER_BYTES = itdrc_pkg::LINK_HEADER_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        target_address_we,
  input  wire logic [31:0] target_address_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  frame_byte,
  input  wire logic        frame_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             kind,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic [15:0]      ip_checksum,
  output logic [15:0]      tcp_checksum,
  output logic [6:0]       tcp_check_offset,
  output logic             malformed
);

  localparam int CW = itdrc_pkg::OUT_CNT_W + 1;

  logic [31:0]                        target_address;
  logic                               accept;
  logic                               item_valid;
  itdrc_pkg::parse_item_t             item;
  logic                               patch_pending;
  logic                               res_valid;
  itdrc_pkg::result_t                 res;
  itdrc_pkg::result_t                 head;
  logic [itdrc_pkg::OUT_CNT_W-1:0]    fifo_count;
  logic [CW-1:0]                      committed;

  // Target address register.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_address <= '0;
    end else if (target_address_we) begin
      target_address <= target_address_wdata;
    end
  end

  // Take a word only when the queue has room for everything in flight plus
  // the two words a last byte can produce.
  always_comb begin
    committed = CW'(fifo_count) + CW'(item_valid) + CW'(res_valid) + CW'(2);
    in_ready  = !patch_pending && (committed <= CW'(itdrc_pkg::OUT_DEPTH));
  end

  assign accept = in_valid && in_ready;

  itdrc_parse #(
    .MAX_FRAME         (MAX_FRAME),
    .LINK_HEADER_BYTES (LINK_HEADER_BYTES)
  ) u_parse (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .frame_byte     (frame_byte),
    .frame_last     (frame_last),
    .target_address (target_address),
    .item_valid     (item_valid),
    .item           (item),
    .patch_pending  (patch_pending)
  );

  itdrc_finish u_finish (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .res_valid  (res_valid),
    .res        (res)
  );

  itdrc_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pop       (out_valid && out_ready),
    .head      (head),
    .not_empty (out_valid),
    .count     (fifo_count)
  );

  // Output fields from the queue head.
  assign kind             = head.kind;
  assign out_byte         = head.out_byte;
  assign out_last         = head.out_last;
  assign ip_checksum      = head.ip_checksum;
  assign tcp_checksum     = head.tcp_checksum;
  assign tcp_check_offset = head.tcp_check_offset;
  assign malformed        = head.malformed;

endmodule

`default_nettype wire
